// ----- src/apbb_pkg.sv -----
// Shared constants and register index codes for the affine point transform block.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package apbb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF  = 20;
  localparam int FRAC_BITS       = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int REG_IDX_W       = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_ROW2  = 3'd2,
    REG_OFF_X = 3'd3,
    REG_OFF_Y = 3'd4,
    REG_OFF_Z = 3'd5
  } reg_idx_t;

endpackage

`default_nettype wire

// ----- src/apbb_queue.sv -----
// Small register FIFO between the front and back of the point transform.
// Depends on apbb_pkg for the default depth (a power of two).
`default_nettype none

module apbb_queue #(
  parameter int WIDTH = 97,
  parameter int DEPTH = apbb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             rd_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr_en |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd_en |-> rd_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count past depth");

endmodule

`default_nettype wire

// ----- src/apbb_front.sv -----
// Input stage: takes points off the input channel and pushes them into the queue.
// Depends on apbb_pkg for the default coordinate width.
`default_nettype none

module apbb_front #(
  parameter int COORD_WIDTH = apbb_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic                          first_point,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [3*COORD_WIDTH:0]        q_data
);

  logic                   held;
  logic [3*COORD_WIDTH:0] item;

  // a held transaction leaves whenever the queue has room
  assign q_push   = held && !q_full;
  assign in_ready = !held || !q_full;
  assign q_data   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= {first_point, point_z, point_y, point_x};
    end
  end

endmodule

`default_nettype wire

// ----- src/apbb_back.sv -----
// Transform pipeline: configuration registers, 3x3 multiply, offset add with
// saturation, bounding box update and output register. Depends on apbb_pkg.
`default_nettype none

module apbb_back #(
  parameter int COORD_WIDTH = apbb_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = apbb_pkg::COEF_WIDTH_DEF,
  parameter int CFG_WIDTH   = 60
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [apbb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_WIDTH-1:0]            cfg_data,
  input  logic                            q_valid,
  input  logic [3*COORD_WIDTH:0]          q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_WIDTH-1:0]   out_x,
  output logic signed [COORD_WIDTH-1:0]   out_y,
  output logic signed [COORD_WIDTH-1:0]   out_z,
  output logic signed [COORD_WIDTH-1:0]   box_min_x,
  output logic signed [COORD_WIDTH-1:0]   box_min_y,
  output logic signed [COORD_WIDTH-1:0]   box_min_z,
  output logic signed [COORD_WIDTH-1:0]   box_max_x,
  output logic signed [COORD_WIDTH-1:0]   box_max_y,
  output logic signed [COORD_WIDTH-1:0]   box_max_z
);

  localparam int W  = COORD_WIDTH;
  localparam int C  = COEF_WIDTH;
  localparam int RW = 3 * C;
  localparam int PW = W + C;
  localparam int SW = PW + 2;

  localparam logic [RW-1:0] ROW_RST0 = RW'(1) << apbb_pkg::FRAC_BITS;
  localparam logic [RW-1:0] ROW_RST1 = ROW_RST0 << C;
  localparam logic [RW-1:0] ROW_RST2 = ROW_RST0 << (2 * C);

  logic [RW-1:0] row_reg [3];
  logic [W-1:0]  off_reg [3];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_reg[0] <= ROW_RST0;
      row_reg[1] <= ROW_RST1;
      row_reg[2] <= ROW_RST2;
      off_reg[0] <= '0;
      off_reg[1] <= '0;
      off_reg[2] <= '0;
    end else if (cfg_write) begin
      case (apbb_pkg::reg_idx_t'(cfg_index))
        apbb_pkg::REG_ROW0:  row_reg[0] <= cfg_data[RW-1:0];
        apbb_pkg::REG_ROW1:  row_reg[1] <= cfg_data[RW-1:0];
        apbb_pkg::REG_ROW2:  row_reg[2] <= cfg_data[RW-1:0];
        apbb_pkg::REG_OFF_X: off_reg[0] <= cfg_data[W-1:0];
        apbb_pkg::REG_OFF_Y: off_reg[1] <= cfg_data[W-1:0];
        apbb_pkg::REG_OFF_Z: off_reg[2] <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline moves together; hold while the output waits
  logic advance;
  assign advance = !out_valid || out_ready;
  assign q_pop   = advance && q_valid;

  logic signed [W-1:0]  pt   [3];
  logic signed [C-1:0]  coef [3][3];
  logic signed [PW-1:0] mul  [3][3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pt[c] = q_data[c*W +: W];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = row_reg[r][c*C +: C];
        mul[r][c]  = PW'(pt[c]) * PW'(coef[r][c]);
      end
    end
  end

  // stage 1: products
  logic                 v1, f1;
  logic signed [PW-1:0] prod [3][3];

  // stage 2: pair sums
  logic                 v2, f2;
  logic signed [SW-1:0] sum_a [3];
  logic signed [SW-1:0] sum_b [3];

  // stage 3: saturated result
  logic                 v3, f3;
  logic signed [W-1:0]  res [3];

  // stage 4: output register and box
  logic signed [W-1:0]  pt_out [3];
  logic signed [W-1:0]  box_lo [3];
  logic signed [W-1:0]  box_hi [3];

  logic signed [SW-1:0] total    [3];
  logic signed [W-1:0]  res_next [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      total[r] = sum_a[r] + sum_b[r];
      if (!total[r][SW-1] && (|total[r][SW-2:W-1])) begin
        res_next[r] = {1'b0, {(W-1){1'b1}}};
      end else if (total[r][SW-1] && !(&total[r][SW-2:W-1])) begin
        res_next[r] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_next[r] = total[r][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1 <= q_data[3*W];
      f2 <= f1;
      f3 <= f2;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= mul[r][c];
        end
        sum_a[r] <= SW'(prod[r][0] >>> apbb_pkg::FRAC_BITS)
                  + SW'(prod[r][1] >>> apbb_pkg::FRAC_BITS);
        sum_b[r] <= SW'(prod[r][2] >>> apbb_pkg::FRAC_BITS)
                  + SW'($signed(off_reg[r]));
        res[r]   <= res_next[r];
      end
      if (v3) begin
        for (int r = 0; r < 3; r++) begin
          pt_out[r] <= res[r];
        end
      end
    end
  end

  // box state; a first point restarts it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        box_lo[r] <= '0;
        box_hi[r] <= '0;
      end
    end else if (advance && v3) begin
      for (int r = 0; r < 3; r++) begin
        if (f3 || (res[r] < box_lo[r])) begin
          box_lo[r] <= res[r];
        end
        if (f3 || (res[r] > box_hi[r])) begin
          box_hi[r] <= res[r];
        end
      end
    end
  end

  assign out_x     = pt_out[0];
  assign out_y     = pt_out[1];
  assign out_z     = pt_out[2];
  assign box_min_x = box_lo[0];
  assign box_min_y = box_lo[1];
  assign box_min_z = box_lo[2];
  assign box_max_x = box_hi[0];
  assign box_max_y = box_hi[1];
  assign box_max_z = box_hi[2];

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    box_lo[0] <= box_hi[0] && box_lo[1] <= box_hi[1] && box_lo[2] <= box_hi[2])
    else $error("box corners out of order");
  a_point_in_box: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> box_lo[0] <= pt_out[0] && pt_out[0] <= box_hi[0]
              && box_lo[1] <= pt_out[1] && pt_out[1] <= box_hi[1]
              && box_lo[2] <= pt_out[2] && pt_out[2] <= box_hi[2])
    else $error("output point outside box");
  a_first_restarts: assert property (@(posedge clk) disable iff (rst)
    advance && v3 && f3 |=> box_lo[0] == pt_out[0] && box_hi[0] == pt_out[0]
                         && box_lo[2] == pt_out[2] && box_hi[2] == pt_out[2])
    else $error("first point did not restart box");

endmodule

`default_nettype wire

// ----- src/affine_point_transform_bbox.sv -----
// Top level of the affine point transform with running bounding box.
// Depends on apbb_pkg, apbb_front, apbb_queue and apbb_back.
//
// Each point (signed Q16.16) is multiplied by a 3x3 matrix of signed Q4.16
// coefficients, each product floored by 16 bits, the translation added and the
// sum saturated; the result updates an axis-aligned box that first_point
// restarts. One point is accepted per cycle sustained while the queue has room;
// an accepted point passes from the front register into the queue, then through
// four back stages: nine parallel multipliers, pair sums, final add with
// saturation, box update into the output register.
// A four-entry queue lets the input keep flowing while the output is held.
// Write configuration only while no point is in flight.
`default_nettype none

module affine_point_transform_bbox #(
  parameter int COORD_WIDTH = apbb_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = apbb_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [apbb_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0] cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         point_x,
  input  logic signed [COORD_WIDTH-1:0]         point_y,
  input  logic signed [COORD_WIDTH-1:0]         point_z,
  input  logic                                  first_point,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_WIDTH-1:0]         out_x,
  output logic signed [COORD_WIDTH-1:0]         out_y,
  output logic signed [COORD_WIDTH-1:0]         out_z,
  output logic signed [COORD_WIDTH-1:0]         box_min_x,
  output logic signed [COORD_WIDTH-1:0]         box_min_y,
  output logic signed [COORD_WIDTH-1:0]         box_min_z,
  output logic signed [COORD_WIDTH-1:0]         box_max_x,
  output logic signed [COORD_WIDTH-1:0]         box_max_y,
  output logic signed [COORD_WIDTH-1:0]         box_max_z
);

  localparam int CFG_WIDTH = (3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH;
  localparam int ITEM_W    = 3*COORD_WIDTH + 1;

  logic              q_full;
  logic              q_push;
  logic [ITEM_W-1:0] q_wr_data;
  logic              q_pop;
  logic [ITEM_W-1:0] q_rd_data;
  logic              q_valid;

  apbb_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .first_point(first_point),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  apbb_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(apbb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .rd_valid(q_valid)
  );

  apbb_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH),
    .CFG_WIDTH  (CFG_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .box_min_x(box_min_x),
    .box_min_y(box_min_y),
    .box_min_z(box_min_z),
    .box_max_x(box_max_x),
    .box_max_y(box_max_y),
    .box_max_z(box_max_z)
  );

endmodule

`default_nettype wire

// ----- verif/affine_point_transform_bbox_test.sv -----
// Self-checking testbench for affine_point_transform_bbox: directed and random point sets
// through the valid/ready channels, checked against an in-bench fixed-point transform model.
// Depends on apbb_pkg and the block's RTL; reads no files.
`default_nettype none

module affine_point_transform_bbox_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = apbb_pkg::COORD_WIDTH_DEF;
  localparam int KW = apbb_pkg::COEF_WIDTH_DEF;
  localparam int IW = apbb_pkg::REG_IDX_W;
  localparam int FB = apbb_pkg::FRAC_BITS;
  localparam int DW = (3 * KW > CW) ? 3 * KW : CW;
  localparam int LATENCY = 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int SEGMENT_POINTS = 272;
  localparam int HOLD_OFF_CYCLES = 300;

  localparam logic [IW-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [IW-1:0] SPARE_IDX_HI = 3'd7;

  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW - 1){1'b0}}};

  localparam logic [KW-1:0] K_MAX  = {1'b0, {(KW - 1){1'b1}}};
  localparam logic [KW-1:0] K_MIN  = {1'b1, {(KW - 1){1'b0}}};
  localparam logic [KW-1:0] K_ONE  = KW'(1 << FB);
  localparam logic [KW-1:0] K_NEG  = KW'(-(1 << FB));
  localparam logic [KW-1:0] K_ZERO = '0;

  typedef struct packed {
    logic [2:0][CW-1:0] pos;
    logic               first;
  } point_t;

  typedef struct packed {
    logic [2:0][CW-1:0] pos;
    logic [2:0][CW-1:0] lo;
    logic [2:0][CW-1:0] hi;
  } result_t;

  class transform_scoreboard;
    logic [DW-1:0] rows[3];
    coord_t        offsets[3];
    coord_t        low_corner[3];
    coord_t        high_corner[3];
    result_t       awaited[$];
    string         axes[3];
    int unsigned   accepted;
    int unsigned   checked;
    int unsigned   saturated;
    int unsigned   mismatches;

    function new();
      axes = '{"x", "y", "z"};
      rows[0] = DW'(1) << FB;
      rows[1] = DW'(1) << (FB + KW);
      rows[2] = DW'(1) << (FB + 2 * KW);
      for (int i = 0; i < 3; i++) begin
        offsets[i] = '0;
        low_corner[i] = '0;
        high_corner[i] = '0;
      end
    endfunction

    function void write_register(logic [IW-1:0] idx, logic [DW-1:0] data);
      case (idx)
        apbb_pkg::REG_ROW0, apbb_pkg::REG_ROW1, apbb_pkg::REG_ROW2: begin
          rows[idx[1:0]] = data;
        end
        apbb_pkg::REG_OFF_X, apbb_pkg::REG_OFF_Y, apbb_pkg::REG_OFF_Z: begin
          offsets[2'(idx - apbb_pkg::REG_OFF_X)] = data[CW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Floor each product by the fraction bits, sum exactly, then saturate.
    function void note_point(point_t p);
      longint               acc;
      longint               term;
      logic signed [KW-1:0] k;
      coord_t               r[3];
      result_t              e;
      for (int row = 0; row < 3; row++) begin
        acc = longint'(offsets[row]);
        for (int col = 0; col < 3; col++) begin
          k = rows[row][col*KW +: KW];
          term = longint'($signed(p.pos[col])) * longint'(k);
          acc += term >>> FB;
        end
        if (acc > COORD_MAX) begin
          acc = COORD_MAX;
          saturated++;
        end else if (acc < COORD_MIN) begin
          acc = COORD_MIN;
          saturated++;
        end
        r[row] = coord_t'(acc);
      end
      for (int i = 0; i < 3; i++) begin
        if (p.first) begin
          low_corner[i] = r[i];
          high_corner[i] = r[i];
        end else begin
          if (r[i] < low_corner[i]) low_corner[i] = r[i];
          if (r[i] > high_corner[i]) high_corner[i] = r[i];
        end
        e.pos[i] = r[i];
        e.lo[i] = low_corner[i];
        e.hi[i] = high_corner[i];
      end
      awaited = {awaited, e};
      accepted++;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at result %0d: %s", checked, what);
    endfunction

    function void compare(string name, logic [CW-1:0] want, logic [CW-1:0] got);
      if (want !== got)
        flag($sformatf("%s expected %0d, got %0d", name, $signed(want), $signed(got)));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        flag("result arrived with no point outstanding");
        return;
      end
      want = awaited.pop_front();
      for (int i = 0; i < 3; i++) begin
        compare({"out_", axes[i]}, want.pos[i], got.pos[i]);
        compare({"box_min_", axes[i]}, want.lo[i], got.lo[i]);
        compare({"box_max_", axes[i]}, want.hi[i], got.hi[i]);
      end
      checked++;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          cfg_write;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_data;
  logic          in_valid;
  logic          in_ready;
  coord_t        point_x;
  coord_t        point_y;
  coord_t        point_z;
  logic          first_point;
  logic          out_valid;
  logic          out_ready;
  coord_t        out_x;
  coord_t        out_y;
  coord_t        out_z;
  coord_t        box_min_x;
  coord_t        box_min_y;
  coord_t        box_min_z;
  coord_t        box_max_x;
  coord_t        box_max_y;
  coord_t        box_max_z;

  transform_scoreboard sb = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned hold_off_request;
  int unsigned input_stalls;
  int unsigned sets_started;
  int unsigned settings_applied;

  affine_point_transform_bbox dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .first_point(first_point),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .box_min_x  (box_min_x),
    .box_min_y  (box_min_y),
    .box_min_z  (box_min_z),
    .box_max_x  (box_max_x),
    .box_max_y  (box_max_y),
    .box_max_z  (box_max_z)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Note accepted points before checking results taken at the same edge.
  always @(posedge clk) begin : monitor
    point_t  p;
    result_t r;
    if (!rst) begin
      if (in_valid && !in_ready) input_stalls++;
      if (in_valid && in_ready) begin
        p.pos = {point_z, point_y, point_x};
        p.first = first_point;
        sb.note_point(p);
      end
      if (out_valid && out_ready) begin
        r.pos = {out_z, out_y, out_x};
        r.lo = {box_min_z, box_min_y, box_min_x};
        r.hi = {box_max_z, box_max_y, box_max_x};
        sb.check_result(r);
      end
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles, %0d results outstanding", cycles, sb.outstanding());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [DW-1:0] rand_wide();
    return DW'({$urandom, $urandom});
  endfunction

  function automatic logic [DW-1:0] pack_row(logic [KW-1:0] cx, logic [KW-1:0] cy,
                                             logic [KW-1:0] cz);
    return DW'({cz, cy, cx});
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0, 1: return coord_t'($urandom);
      2: begin
        case ($urandom_range(4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
      default: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  // Mostly within +/-2.0 so that sets do not all pin to the rails.
  function automatic logic [KW-1:0] rand_coef();
    if ($urandom_range(3) == 0) return KW'($urandom);
    return KW'(int'($urandom_range(0, 262144)) - 131072);
  endfunction

  // Called at a clock edge; returns at the edge where the transaction is taken.
  task automatic offer_point(coord_t x, coord_t y, coord_t z, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    first_point <= first;
    if (first) sets_started++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_register(idx, data);
    @(posedge clk);
  endtask

  // Offsets carry junk above their width; the spare indexes must be ignored.
  task automatic program_transform(logic [DW-1:0] r0, logic [DW-1:0] r1, logic [DW-1:0] r2,
                                   coord_t ox, coord_t oy, coord_t oz);
    logic [DW-1:0] junk;
    write_reg(apbb_pkg::REG_ROW0, r0);
    write_reg(apbb_pkg::REG_ROW1, r1);
    write_reg(apbb_pkg::REG_ROW2, r2);
    junk = rand_wide();
    junk[CW-1:0] = ox;
    write_reg(apbb_pkg::REG_OFF_X, junk);
    junk = rand_wide();
    junk[CW-1:0] = oy;
    write_reg(apbb_pkg::REG_OFF_Y, junk);
    junk = rand_wide();
    junk[CW-1:0] = oz;
    write_reg(apbb_pkg::REG_OFF_Z, junk);
    write_reg(SPARE_IDX_LO, rand_wide());
    write_reg(SPARE_IDX_HI, rand_wide());
    cfg_write <= 1'b0;
    settings_applied++;
    @(posedge clk);
  endtask

  task automatic program_random_transform(bit scale_only);
    logic [DW-1:0] r[3];
    for (int i = 0; i < 3; i++) begin
      if (scale_only) begin
        r[i] = '0;
        r[i][i*KW +: KW] = rand_coef();
      end else begin
        r[i] = pack_row(rand_coef(), rand_coef(), rand_coef());
      end
    end
    program_transform(r[0], r[1], r[2], rand_coord(), rand_coord(), rand_coord());
  endtask

  // Mostly whole sets led by first_point; one in ten has the flag scattered at random.
  task automatic offer_sets(int count);
    int  sent;
    int  len;
    bit  broken;
    sent = 0;
    while (sent < count) begin
      len = int'($urandom_range(1, 12));
      broken = ($urandom_range(9) == 0);
      for (int j = 0; j < len && sent < count; j++) begin
        offer_point(rand_coord(), rand_coord(), rand_coord(),
                    broken ? 1'($urandom_range(1)) : (j == 0));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    point_x <= '0;
    point_y <= '0;
    point_z <= '0;
    first_point <= 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 47;
    hold_off_request = 0;
    input_stalls = 0;
    sets_started = 0;
    settings_applied = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset transform; the first points merge into the box at the origin.
    offer_point(32'h0003_0000, 32'hFFFB_0000, 32'h0007_0000, 1'b0);
    offer_point(C_MAX, C_MIN, '0, 1'b0);
    offer_point('1, coord_t'(1), C_MAX, 1'b0);
    offer_point(32'h000A_0000, 32'h0014_0000, 32'h001E_0000, 1'b1);
    offer_point(C_MIN, C_MIN, C_MIN, 1'b0);
    offer_point(C_MAX, C_MAX, C_MAX, 1'b0);
    drain();

    // Extreme coefficients and offsets: drive the x and y sums to both rails, z to the low one.
    program_transform(pack_row(K_MAX, K_MAX, K_MAX), pack_row(K_MIN, K_MIN, K_MIN),
                      pack_row(K_MIN, K_ZERO, K_MAX), C_MAX, C_MIN, '1);
    offer_point(C_MAX, C_MAX, C_MAX, 1'b1);
    offer_point(C_MIN, C_MIN, C_MIN, 1'b0);
    offer_point('0, '0, '0, 1'b0);
    offer_point('1, '1, '1, 1'b0);
    offer_point(coord_t'(1), '0, C_MIN, 1'b1);
    offer_point(C_MAX, C_MIN, '0, 1'b0);
    drain();

    // Quarter turn about z plus a translation; odd fractions exercise the floor.
    program_transform(pack_row(K_ZERO, K_NEG, K_ZERO), pack_row(K_ONE, K_ZERO, K_ZERO),
                      pack_row(K_ZERO, K_ZERO, K_ONE),
                      32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000);
    offer_point(32'h0001_0000, '0, '0, 1'b1);
    offer_point('0, 32'h0001_0000, '0, 1'b0);
    offer_point(32'hFFFF_8001, 32'h0000_7FFF, 32'hFFFF_FFFF, 1'b0);
    offer_point(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0001, 1'b0);
    offer_point(32'hFFFF_0000, 32'h8000_0001, 32'h7FFF_0000, 1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        program_random_transform(phase == 2 && seg == 0);
        // Hold the output off while points keep coming, so the queue fills.
        if (phase == 2 && seg == 1) hold_off_request = HOLD_OFF_CYCLES;
        offer_sets(SEGMENT_POINTS);
        drain();
      end
    end

    $display("Covered %0d points in %0d sets under %0d register settings, %0d saturated.",
             sb.accepted, sb.checked == 0 ? 0 : sets_started, settings_applied,
             sb.saturated);
    $display("Input held back for %0d cycles; %0d results checked, %0d mismatches.",
             input_stalls, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/apbb_pkg.sv
src/apbb_queue.sv
src/apbb_front.sv
src/apbb_back.sv
src/affine_point_transform_bbox.sv
verif/affine_point_transform_bbox_test.sv
